// ----- rtl/bar_pkg.sv -----
// Shared types, constants and helpers for the button auto-repeat block.
// No dependencies; imported by every module of the block.

package bar_pkg;

	localparam int BUTTONS = 16;
	localparam int BIDX_W  = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;
	localparam int BTN_W   = 16;
	localparam int LO_W    = $clog2(BTN_W + 1);
	localparam int TIME_W  = 48;
	localparam int DUR_W   = 32;
	localparam int IN_W    = 88;
	localparam int OUT_W   = 40;
	localparam int ADDR_W  = 4;
	localparam int DATA_W  = 32;

	// register indexes (byte address = 4 * index)
	localparam logic [1:0] REG_MASK     = 2'd0;
	localparam logic [1:0] REG_DELAY    = 2'd1;
	localparam logic [1:0] REG_INTERVAL = 2'd2;

	localparam logic [BTN_W-1:0] MASK_RST     = '0;
	localparam logic [DUR_W-1:0] DELAY_RST    = 32'd300000;
	localparam logic [DUR_W-1:0] INTERVAL_RST = 32'd100000;

	typedef struct packed {
		logic [BTN_W-1:0] mask;
		logic [DUR_W-1:0] delay;
		logic [DUR_W-1:0] interval;
	} cfg_t;

	typedef struct packed {
		logic              hold_we;
		logic              last_we;
		logic [BIDX_W-1:0] idx;
		logic [TIME_W-1:0] hold_d;
		logic [TIME_W-1:0] last_d;
	} tmr_wr_t;

	// index of the lowest set bit, BTN_W when none is set
	function automatic logic [LO_W-1:0] lowest_bit(input logic [BTN_W-1:0] v);
		logic [LO_W-1:0] r;
		r = LO_W'(BTN_W);
		for (int k = BTN_W - 1; k >= 0; k--) begin
			if (v[k]) r = LO_W'(k);
		end
		return r;
	endfunction

endpackage

// ----- rtl/button_auto_repeat.sv -----
// Typematic auto-repeat for 16 buttons. Button events pass straight through and
// start or end the hold timer of their button; polls scan the held repeatable
// buttons in index order and return one synthesized press for the first button
// whose delay and repeat interval have run out, or nothing. A button event is
// accepted, then the event step loads its result into the output register. A poll
// is accepted, then each button is checked in index order: one that is not held or
// fails the delay check is passed over, one that passes it also gets the interval
// check (one shared 49-bit add/compare unit checks delay, then interval), and the
// first button that passes both goes to the emit step, which loads the repeat.
// The event and emit steps stall for as long as the output register stays full.
// The input is not ready while an item is in work; a finished result sits in the
// output register and the next item is accepted while it waits.
// Depends on bar_pkg, bar_regs, bar_timers, bar_cmp.

module button_auto_repeat (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// now_time[47:0], button_mask[63:48], key_down[64], all_pressed[80:65], zero fill
	input  logic [bar_pkg::IN_W-1:0]    s_tdata,
	// mode[0]: 0 button event, 1 poll
	input  logic                        s_tuser,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// event_valid[0], out_button[16:1], out_down[17], out_pressed[33:18], zero fill
	output logic [bar_pkg::OUT_W-1:0]   m_tdata,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bar_pkg::ADDR_W-1:0]  paddr,
	input  logic [bar_pkg::DATA_W-1:0]  pwdata,
	output logic [bar_pkg::DATA_W-1:0]  prdata,
	output logic                        pready
);
	import bar_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EVT  = 3'd1;
	localparam logic [2:0] S_HOLD = 3'd2;
	localparam logic [2:0] S_LAST = 3'd3;
	localparam logic [2:0] S_EMIT = 3'd4;

	localparam logic [BIDX_W-1:0] IDX_LAST = BIDX_W'(BUTTONS - 1);

	cfg_t              cfg;
	tmr_wr_t           twr;
	logic [2:0]        state_q, state_d;
	logic [BIDX_W-1:0] idx_q, idx_d, rd_idx;
	logic [TIME_W-1:0] now_q;
	logic [BTN_W-1:0]  btn_q, all_q, pressed_q;
	logic              down_q;
	logic              m_valid_q;
	logic [BTN_W-1:0]  m_button_q, m_pressed_q;
	logic              m_down_q;
	logic              s_acc, out_free, load_out;
	logic [BTN_W-1:0]  ld_button, ld_pressed;
	logic              ld_down;
	logic [TIME_W-1:0] hold_rd, last_rd, cmp_base;
	logic [DUR_W-1:0]  cmp_span;
	logic              cmp_elapsed, cmp_zero;
	logic [LO_W-1:0]   lo;
	logic              lo_ok, repeatable, held_all, held_none, pending;

	bar_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bar_timers u_timers (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (twr),
		.rd_idx  (rd_idx),
		.hold_rd (hold_rd),
		.last_rd (last_rd)
	);

	bar_cmp u_cmp (
		.base    (cmp_base),
		.span    (cmp_span),
		.now     (now_q),
		.elapsed (cmp_elapsed),
		.is_zero (cmp_zero)
	);

	assign s_tready = state_q == S_IDLE;
	assign s_acc    = s_tvalid & s_tready;
	assign out_free = !m_valid_q || m_tready;

	// event decode
	assign lo         = lowest_bit(btn_q);
	assign lo_ok      = int'(lo) < BUTTONS;
	assign repeatable = (btn_q & ~cfg.mask) == '0;
	assign held_all   = (pressed_q & btn_q) == btn_q;
	assign held_none  = (pressed_q & btn_q) == '0;
	assign pending    = cfg.mask[idx_q] & pressed_q[idx_q];

	assign rd_idx   = idx_q;
	assign cmp_base = (state_q == S_LAST) ? last_rd : hold_rd;
	assign cmp_span = (state_q == S_LAST) ? cfg.interval : cfg.delay;

	// twr.last_d of zero covers both event cases; emit writes now
	always_comb begin
		state_d     = state_q;
		idx_d       = idx_q;
		twr         = '0;
		twr.idx     = idx_q;
		twr.hold_d  = now_q;
		load_out    = 1'b0;
		ld_button   = btn_q;
		ld_down     = down_q;
		ld_pressed  = all_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_acc) begin
					idx_d   = '0;
					state_d = s_tuser ? S_HOLD : S_EVT;
				end
			end
			S_EVT: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
					twr.idx  = lo[BIDX_W-1:0];
					if (repeatable && lo_ok) begin
						if (held_all && !down_q) begin
							twr.hold_we = 1'b1;
							twr.last_we = 1'b1;
							twr.hold_d  = '0;
						end else if (held_none && down_q) begin
							twr.hold_we = 1'b1;
							twr.last_we = 1'b1;
						end
					end
				end
			end
			S_HOLD, S_LAST: begin
				if (pending && state_q == S_HOLD && !cmp_zero && cmp_elapsed) begin
					state_d = S_LAST;
				end else if (pending && state_q == S_LAST && (cmp_zero || cmp_elapsed)) begin
					state_d = S_EMIT;
				end else if (idx_q == IDX_LAST) begin
					state_d = S_IDLE;
				end else begin
					idx_d   = idx_q + 1'b1;
					state_d = S_HOLD;
				end
			end
			S_EMIT: begin
				if (out_free) begin
					load_out    = 1'b1;
					state_d     = S_IDLE;
					twr.last_we = 1'b1;
					twr.last_d  = now_q;
					ld_button   = BTN_W'(1) << idx_q;
					ld_down     = 1'b1;
					ld_pressed  = pressed_q;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			idx_q     <= '0;
			pressed_q <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			if (state_q == S_EVT && out_free) pressed_q <= all_q;
			if (load_out) m_valid_q <= 1'b1;
			else if (m_tready) m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			now_q  <= s_tdata[47:0];
			btn_q  <= s_tdata[63:48];
			down_q <= s_tdata[64];
			all_q  <= s_tdata[80:65];
		end
		if (load_out) begin
			m_button_q  <= ld_button;
			m_down_q    <= ld_down;
			m_pressed_q <= ld_pressed;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {6'd0, m_pressed_q, m_down_q, m_button_q, 1'b1};

	// an accepted poll always starts its scan at the first button
	a_poll_start: assert property (@(posedge clk) disable iff (!arst_n)
		(s_acc && s_tuser) |=> (state_q == S_HOLD && idx_q == '0))
		else $error("poll did not start scan at button zero");

	// interval check only follows a passed delay check
	a_last_after_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LAST) |-> ($past(state_q) == S_HOLD))
		else $error("interval check without delay check");

	// a result appears only from the event or emit step
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_valid_q) |-> ($past(state_q) == S_EVT || $past(state_q) == S_EMIT))
		else $error("result loaded outside event or emit");

	// a repeat writes the timer store and the output in the same cycle
	a_emit_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && out_free) |-> (twr.last_we && twr.last_d == now_q && load_out))
		else $error("repeat emitted without timer update");

endmodule

// ----- rtl/bar_regs.sv -----
// APB-style configuration registers: repeat mask, delay and interval.
// Depends on bar_pkg.

module bar_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bar_pkg::ADDR_W-1:0]  paddr,
	input  logic [bar_pkg::DATA_W-1:0]  pwdata,
	output logic [bar_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	output bar_pkg::cfg_t               cfg
);
	import bar_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	assign reg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mask     <= MASK_RST;
			cfg_q.delay    <= DELAY_RST;
			cfg_q.interval <= INTERVAL_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_MASK:     cfg_q.mask     <= pwdata[BTN_W-1:0];
				REG_DELAY:    cfg_q.delay    <= pwdata[DUR_W-1:0];
				REG_INTERVAL: cfg_q.interval <= pwdata[DUR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_MASK:     prdata = DATA_W'(cfg_q.mask);
			REG_DELAY:    prdata = DATA_W'(cfg_q.delay);
			REG_INTERVAL: prdata = DATA_W'(cfg_q.interval);
			default:      prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

// ----- rtl/bar_timers.sv -----
// Per-button timer store: hold start and last repeat times, zero = unset.
// Depends on bar_pkg. Cleared by reset; one write and one read index.

module bar_timers (
	input  logic                        clk,
	input  logic                        arst_n,
	input  bar_pkg::tmr_wr_t            wr,
	input  logic [bar_pkg::BIDX_W-1:0]  rd_idx,
	output logic [bar_pkg::TIME_W-1:0]  hold_rd,
	output logic [bar_pkg::TIME_W-1:0]  last_rd
);
	import bar_pkg::*;

	logic [TIME_W-1:0] hold_q [BUTTONS];
	logic [TIME_W-1:0] last_q [BUTTONS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < BUTTONS; k++) begin
				hold_q[k] <= '0;
				last_q[k] <= '0;
			end
		end else begin
			if (wr.hold_we) hold_q[wr.idx] <= wr.hold_d;
			if (wr.last_we) last_q[wr.idx] <= wr.last_d;
		end
	end

	assign hold_rd = hold_q[rd_idx];
	assign last_rd = last_q[rd_idx];

endmodule

// ----- rtl/bar_cmp.sv -----
// Shared elapsed-time check: (base + span <= now) and base == 0.
// Depends on bar_pkg. Sum is one bit wider so it never wraps.

module bar_cmp (
	input  logic [bar_pkg::TIME_W-1:0] base,
	input  logic [bar_pkg::DUR_W-1:0]  span,
	input  logic [bar_pkg::TIME_W-1:0] now,
	output logic                       elapsed,
	output logic                       is_zero
);
	import bar_pkg::*;

	logic [TIME_W:0] sum;

	assign sum     = {1'b0, base} + (TIME_W + 1)'(span);
	assign elapsed = sum <= {1'b0, now};
	assign is_zero = base == '0;

endmodule

// ----- test/tb_button_auto_repeat.sv -----
// Self-checking testbench for button_auto_repeat: stream items in, typematic results out.
// Register access over the APB-style port; an in-bench predictor tracks hold and repeat timers.
// Depends on bar_pkg and the button_auto_repeat RTL.

module tb_button_auto_repeat;
	timeunit 1ns;
	timeprecision 1ps;

	import bar_pkg::*;

	localparam int SETTLE_CYCLES = 40;   // longest poll scan plus margin
	localparam int STALL_CYCLES  = 300;

	typedef struct packed {
		logic              mode;
		logic [TIME_W-1:0] now_t;
		logic [BTN_W-1:0]  btn;
		logic              down;
		logic [BTN_W-1:0]  all_p;
	} btn_item_t;

	typedef struct packed {
		logic [BTN_W-1:0] btn;
		logic             down;
		logic [BTN_W-1:0] pressed;
	} key_event_t;

	logic               clk;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	// now_time[47:0], button_mask[63:48], key_down[64], all_pressed[80:65], zero fill
	logic [IN_W-1:0]    s_tdata;
	// mode[0]
	logic               s_tuser;
	logic               m_tvalid;
	logic               m_tready;
	// event_valid[0], out_button[16:1], out_down[17], out_pressed[33:18], zero fill
	logic [OUT_W-1:0]   m_tdata;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [ADDR_W-1:0]  paddr;
	logic [DATA_W-1:0]  pwdata;
	logic [DATA_W-1:0]  prdata;
	logic               pready;

	// predictor state and register shadow
	logic [BTN_W-1:0]   cfg_mask;
	logic [DUR_W-1:0]   cfg_delay;
	logic [DUR_W-1:0]   cfg_interval;
	logic [BTN_W-1:0]   pressed_st;
	logic [TIME_W-1:0]  hold_t [BUTTONS];
	logic [TIME_W-1:0]  last_t [BUTTONS];
	key_event_t         pending_events[$];

	int                 mismatch_cnt;
	int                 tx_idle;
	int                 rx_idle;
	int                 stall_req;
	int                 hold_left;
	logic [TIME_W-1:0]  t_now;
	logic [BTN_W-1:0]   phys;
	int                 step_max;

	button_auto_repeat uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	initial begin
		#2_000_000;
		$display("Some tests failed");
		$finish;
	end

	task automatic note_mismatch(input string msg);
		mismatch_cnt++;
		if (mismatch_cnt <= 10) $display("MISMATCH @%0t: %s", $realtime, msg);
	endtask

	task automatic predict_autorepeat(input btn_item_t it);
		int idx;
		bit found;
		key_event_t ev;
		found = 1'b0;
		if (!it.mode) begin
			if ((it.btn & cfg_mask) == it.btn && it.btn != '0) begin
				idx = 0;
				while (!it.btn[idx]) idx++;
				if ((pressed_st & it.btn) == it.btn && !it.down) begin
					hold_t[idx] = '0;
					last_t[idx] = '0;
				end else if ((pressed_st & it.btn) == '0 && it.down) begin
					hold_t[idx] = it.now_t;
					last_t[idx] = '0;
				end
			end
			pressed_st = it.all_p;
			ev = '{it.btn, it.down, it.all_p};
			pending_events.push_back(ev);
		end else begin
			for (int i = 0; i < BUTTONS; i++) begin
				if (!found && cfg_mask[i] && pressed_st[i] && hold_t[i] != '0
						&& 64'(hold_t[i]) + 64'(cfg_delay) <= 64'(it.now_t)) begin
					if (last_t[i] == '0
							|| 64'(last_t[i]) + 64'(cfg_interval) <= 64'(it.now_t)) begin
						last_t[i] = it.now_t;
						found = 1'b1;
						ev = '{BTN_W'(1) << i, 1'b1, pressed_st};
						pending_events.push_back(ev);
					end
				end
			end
		end
	endtask

	// result checker
	always @(posedge clk) begin : result_check
		key_event_t want;
		if (m_tvalid && m_tready) begin
			if (pending_events.size() == 0) begin
				note_mismatch($sformatf("unexpected result %h", m_tdata));
			end else begin
				want = pending_events.pop_front();
				if (m_tdata[0] !== 1'b1 || m_tdata[16:1] !== want.btn
						|| m_tdata[17] !== want.down || m_tdata[33:18] !== want.pressed
						|| m_tdata[OUT_W-1:34] !== '0)
					note_mismatch($sformatf(
						"exp valid 1 btn %h down %b pressed %h | got valid %b btn %h down %b pressed %h pad %h",
						want.btn, want.down, want.pressed, m_tdata[0], m_tdata[16:1],
						m_tdata[17], m_tdata[33:18], m_tdata[OUT_W-1:34]));
			end
		end
	end

	// result side: random back-pressure plus one long hold-off on request
	always @(negedge clk) begin
		if (stall_req) begin
			hold_left = STALL_CYCLES;
			stall_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_idle);
		end
	end

	function automatic btn_item_t mk_item(input logic mode, input logic [TIME_W-1:0] t,
			input logic [BTN_W-1:0] btn, input logic down, input logic [BTN_W-1:0] all_p);
		btn_item_t it;
		it = '{mode, t, btn, down, all_p};
		return it;
	endfunction

	task automatic send_item(input btn_item_t it);
		while ($urandom_range(99) < tx_idle) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= it.mode;
		s_tdata  <= {{(IN_W - 81){1'b0}}, it.all_p, it.down, it.btn, it.now_t};
		do @(posedge clk); while (!s_tready);
		predict_autorepeat(it);
	endtask

	// drop valid and let the block drain before a register write
	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_events.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_check(input logic [1:0] idx, input logic [DATA_W-1:0] want);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== want)
			note_mismatch($sformatf("register %0d read exp %h got %h", idx, want, prdata));
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_reg(input logic [1:0] idx, input logic [DATA_W-1:0] val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		case (idx)
			REG_MASK:     cfg_mask     = val[BTN_W-1:0];
			REG_DELAY:    cfg_delay    = val;
			REG_INTERVAL: cfg_interval = val;
			default: ;
		endcase
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		apb_check(idx, val);
	endtask

	task automatic test_reg_access();
		apb_check(REG_MASK, DATA_W'(MASK_RST));
		apb_check(REG_DELAY, DATA_W'(DELAY_RST));
		apb_check(REG_INTERVAL, DATA_W'(INTERVAL_RST));
		set_reg(REG_MASK, 32'h0000_00FF);
		set_reg(REG_DELAY, 32'd100);
		set_reg(REG_INTERVAL, 32'd40);
	endtask

	task automatic test_events_and_polls();
		send_item(mk_item(1'b0, 48'd1000, 16'h0001, 1'b1, 16'h0001));
		// poll too early; event fields are junk and must be ignored
		send_item(mk_item(1'b1, 48'd1050, 16'hFFFF, 1'b1, 16'hFFFF));
		send_item(mk_item(1'b1, 48'd1100, 16'h0000, 1'b0, 16'h0000));
		send_item(mk_item(1'b1, 48'd1139, 16'h0000, 1'b0, 16'h0000));
		send_item(mk_item(1'b1, 48'd1140, 16'h0000, 1'b0, 16'h0000));
		// press of an already held button
		send_item(mk_item(1'b0, 48'd1150, 16'h0001, 1'b1, 16'h0001));
		// button outside the repeat mask
		send_item(mk_item(1'b0, 48'd1160, 16'h0100, 1'b1, 16'h0101));
		// two bits at once, both repeatable
		send_item(mk_item(1'b0, 48'd1170, 16'h0006, 1'b1, 16'h0107));
		// release of a button that is not pressed
		send_item(mk_item(1'b0, 48'd1180, 16'h0008, 1'b0, 16'h0107));
		send_item(mk_item(1'b0, 48'd1190, 16'h0006, 1'b0, 16'h0101));
		// empty button mask
		send_item(mk_item(1'b0, 48'd1200, 16'h0000, 1'b1, 16'h0101));
		// press at time zero leaves the button looking not held
		send_item(mk_item(1'b0, 48'd0, 16'h0080, 1'b1, 16'h0181));
		send_item(mk_item(1'b1, 48'd5000, 16'h0000, 1'b0, 16'h0000));
		send_item(mk_item(1'b1, 48'd5000, 16'h0000, 1'b0, 16'h0000));
		send_item(mk_item(1'b0, 48'd5010, 16'h0001, 1'b0, 16'h0180));
		send_item(mk_item(1'b0, {TIME_W{1'b1}}, 16'h8000, 1'b1, 16'hFFFF));
	endtask

	task automatic test_time_extremes();
		settle();
		set_reg(REG_MASK, 32'h0000_FFFF);
		set_reg(REG_DELAY, 32'hFFFF_FFFF);
		set_reg(REG_INTERVAL, 32'hFFFF_FFFF);
		send_item(mk_item(1'b0, 48'd7, 16'hFFFF, 1'b0, 16'h0000));
		// sums near the top of the time range must not wrap
		send_item(mk_item(1'b0, {TIME_W{1'b1}} - 48'd15, 16'h8000, 1'b1, 16'h8000));
		send_item(mk_item(1'b1, {TIME_W{1'b1}}, 16'h0000, 1'b0, 16'h0000));
		send_item(mk_item(1'b0, 48'd1, 16'h4000, 1'b1, 16'hC000));
		send_item(mk_item(1'b1, {TIME_W{1'b1}}, 16'h0000, 1'b0, 16'h0000));
		send_item(mk_item(1'b1, {TIME_W{1'b1}}, 16'h0000, 1'b0, 16'h0000));
		settle();
		set_reg(REG_DELAY, 32'd0);
		set_reg(REG_INTERVAL, 32'd0);
		send_item(mk_item(1'b1, {TIME_W{1'b1}}, 16'h0000, 1'b0, 16'h0000));
		send_item(mk_item(1'b1, {TIME_W{1'b1}}, 16'h0000, 1'b0, 16'h0000));
		send_item(mk_item(1'b0, 48'd2, 16'hC000, 1'b0, 16'h0000));
	endtask

	task automatic send_random_item();
		btn_item_t it;
		int pick;
		int b;
		pick  = $urandom_range(99);
		t_now = t_now + TIME_W'($urandom_range(0, step_max));
		it    = mk_item(1'b1, t_now, BTN_W'($urandom), 1'($urandom), BTN_W'($urandom));
		if (pick < 20) begin
			b = $urandom_range(BUTTONS - 1);
			it = mk_item(1'b0, t_now, BTN_W'(1) << b, 1'b1, phys | (BTN_W'(1) << b));
		end else if (pick < 33 && phys != '0) begin
			do b = $urandom_range(BUTTONS - 1); while (!phys[b]);
			it = mk_item(1'b0, t_now, BTN_W'(1) << b, 1'b0, phys & ~(BTN_W'(1) << b));
		end else if (pick < 40) begin
			// noise: arbitrary time and fields
			it.mode  = 1'b0;
			it.now_t = {16'($urandom), 32'($urandom)};
		end
		if (!it.mode) phys = it.all_p;
		send_item(it);
	endtask

	task automatic test_random(input int count, input int tx_pct, input int rx_pct);
		tx_idle = tx_pct;
		rx_idle = rx_pct;
		repeat (count) send_random_item();
	endtask

	task automatic test_backpressure();
		tx_idle = 0;
		rx_idle = 0;
		@(posedge clk);
		stall_req = 1;
		repeat (12) send_random_item();
	endtask

	initial begin
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tuser      = 1'b0;
		s_tdata      = '0;
		m_tready     = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		mismatch_cnt = 0;
		tx_idle      = 13;
		rx_idle      = 53;
		stall_req    = 0;
		hold_left    = 0;
		cfg_mask     = MASK_RST;
		cfg_delay    = DELAY_RST;
		cfg_interval = INTERVAL_RST;
		pressed_st   = '0;
		phys         = '0;
		step_max     = 1200;
		for (int i = 0; i < BUTTONS; i++) begin
			hold_t[i] = '0;
			last_t[i] = '0;
		end
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reg_access();
		test_events_and_polls();
		test_time_extremes();

		settle();
		set_reg(REG_MASK, 32'h0000_FFFF);
		set_reg(REG_DELAY, 32'd3000);
		set_reg(REG_INTERVAL, 32'd700);
		t_now    = {16'($urandom_range(1, 255)), 32'h0};
		phys     = pressed_st;
		step_max = 1200;
		test_random(185, 13, 53);

		settle();
		set_reg(REG_MASK, 32'($urandom_range(16'hFFFF)));
		set_reg(REG_DELAY, 32'($urandom_range(0, 4000)));
		set_reg(REG_INTERVAL, 32'($urandom_range(0, 1500)));
		step_max = 900;
		test_random(185, 53, 13);

		test_backpressure();

		settle();
		set_reg(REG_MASK, 32'($urandom_range(16'hFFFF)) | 32'h0000_0F0F);
		set_reg(REG_DELAY, 32'($urandom_range(0, 2000)));
		set_reg(REG_INTERVAL, 32'd0);
		step_max = 600;
		test_random(185, 0, 0);

		@(negedge clk);
		s_tvalid <= 1'b0;
		for (int n = 0; n < 5000 && pending_events.size() != 0; n++) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_events.size() != 0)
			note_mismatch($sformatf("%0d results never arrived", pending_events.size()));
		if (mismatch_cnt == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/bar_pkg.sv
rtl/bar_regs.sv
rtl/bar_timers.sv
rtl/bar_cmp.sv
rtl/button_auto_repeat.sv
test/tb_button_auto_repeat.sv
